@@ design/isf_pkg.sv @@
// shared types and constants of the informative site filter
`timescale 1ns / 1ps

package isf_pkg;

    // store geometry
    localparam int SITES   = 4096;
    localparam int ADDR_W  = (SITES > 1) ? $clog2(SITES) : 1;
    localparam int SITE_W  = 12;
    localparam int CHAR_W  = 8;
    localparam int CNT_W   = 2;
    localparam int LANES   = 4;
    localparam int LANE_W  = 2;
    localparam int WORD_W  = CNT_W * LANES;
    localparam int KINDS_W = 3;

    // a counter at this level means the base occurs at least twice
    localparam logic [CNT_W-1:0] SAT_LEVEL = 2'd2;

    // bases needed at saturation for an informative site
    localparam logic [KINDS_W-1:0] KEEP_MIN = 3'd2;

    // result queue
    localparam int OQ_DEPTH = 2;
    localparam int OQ_PTR_W = 1;
    localparam int OQ_CNT_W = 2;

    // nucleotide characters
    localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T_UP = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_C_LO = 8'h63;
    localparam logic [CHAR_W-1:0] CHAR_G_LO = 8'h67;
    localparam logic [CHAR_W-1:0] CHAR_T_LO = 8'h74;

    // lanes within one store word
    localparam logic [LANE_W-1:0] LANE_A = 2'd0;
    localparam logic [LANE_W-1:0] LANE_C = 2'd1;
    localparam logic [LANE_W-1:0] LANE_G = 2'd2;
    localparam logic [LANE_W-1:0] LANE_T = 2'd3;

    typedef enum logic {
        OP_COUNT    = 1'b0,
        OP_CLASSIFY = 1'b1
    } opcode_t;

    typedef struct packed {
        logic                keep;
        logic [KINDS_W-1:0]  kinds;
    } result_t;

endpackage

@@ design/isf_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module isf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/isf_rmw.sv @@
// read-modify-write of the per-site base counters, with clearing pass
`timescale 1ns / 1ps

module isf_rmw (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_fire,
    input  isf_pkg::opcode_t            in_op,
    input  logic [isf_pkg::SITE_W-1:0]  in_site,
    input  logic [isf_pkg::CHAR_W-1:0]  in_char,
    output logic                        clearing,
    output logic                        pend,
    output logic                        push,
    output isf_pkg::result_t            res
);

    // map a character to {is_base, lane}
    function automatic logic [isf_pkg::LANE_W:0] lane_of(input logic [isf_pkg::CHAR_W-1:0] ch);
        logic [isf_pkg::LANE_W:0] r;
        begin
            unique case (ch)
                isf_pkg::CHAR_A_UP, isf_pkg::CHAR_A_LO: r = {1'b1, isf_pkg::LANE_A};
                isf_pkg::CHAR_C_UP, isf_pkg::CHAR_C_LO: r = {1'b1, isf_pkg::LANE_C};
                isf_pkg::CHAR_G_UP, isf_pkg::CHAR_G_LO: r = {1'b1, isf_pkg::LANE_G};
                isf_pkg::CHAR_T_UP, isf_pkg::CHAR_T_LO: r = {1'b1, isf_pkg::LANE_T};
                default:                                 r = '0;
            endcase
            return r;
        end
    endfunction

    logic                               clearing_reg;
    logic [isf_pkg::ADDR_W-1:0]         clr_addr_reg;

    logic                               s1_valid_reg;
    isf_pkg::opcode_t                   s1_op_reg;
    logic                               s1_site_ok_reg;
    logic                               s1_base_ok_reg;
    logic [isf_pkg::LANE_W-1:0]         s1_lane_reg;
    logic [isf_pkg::ADDR_W-1:0]         s1_addr_reg;

    logic                               fwd_valid_reg;
    logic [isf_pkg::ADDR_W-1:0]         fwd_addr_reg;
    logic [isf_pkg::WORD_W-1:0]         fwd_data_reg;

    logic [isf_pkg::LANE_W:0]           in_lane;
    logic                               in_site_ok;
    logic [isf_pkg::WORD_W-1:0]         rd_word;
    logic [isf_pkg::WORD_W-1:0]         cur_word;
    logic [isf_pkg::WORD_W-1:0]         new_word;
    logic [isf_pkg::CNT_W-1:0]          cur_cnt;
    logic [isf_pkg::KINDS_W-1:0]        kinds;
    logic                               s1_we;

    logic                               ram_we;
    logic [isf_pkg::ADDR_W-1:0]         ram_waddr;
    logic [isf_pkg::WORD_W-1:0]         ram_wdata;

    // decode of the incoming request
    assign in_lane    = lane_of(in_char);
    assign in_site_ok = (32'(in_site) < isf_pkg::SITES);

    // clearing pass after reset, then the request stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == isf_pkg::ADDR_W'(isf_pkg::SITES - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            s1_valid_reg  <= in_fire;
            fwd_valid_reg <= ram_we;
        end
    end

    // payload of the request stage and the forwarding register
    always_ff @(posedge clk)
    begin
        s1_op_reg      <= in_op;
        s1_site_ok_reg <= in_site_ok;
        s1_base_ok_reg <= in_lane[isf_pkg::LANE_W];
        s1_lane_reg    <= in_lane[isf_pkg::LANE_W-1:0];
        s1_addr_reg    <= isf_pkg::ADDR_W'(in_site);
        fwd_addr_reg   <= ram_waddr;
        fwd_data_reg   <= ram_wdata;
    end

    // word written last cycle is not yet visible in the read data
    assign cur_word = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rd_word;
    assign cur_cnt  = cur_word[{s1_lane_reg, 1'b0} +: isf_pkg::CNT_W];

    // modify: saturating increment, or clear on classify
    always_comb
    begin
        new_word = cur_word;
        if (s1_op_reg == isf_pkg::OP_CLASSIFY)
        begin
            new_word = '0;
        end
        else if (cur_cnt < isf_pkg::SAT_LEVEL)
        begin
            new_word[{s1_lane_reg, 1'b0} +: isf_pkg::CNT_W] = cur_cnt + 1'b1;
        end
    end

    // count of saturated lanes
    always_comb
    begin
        kinds = '0;
        for (int i = 0; i < isf_pkg::LANES; i++)
        begin
            if (cur_word[i*isf_pkg::CNT_W +: isf_pkg::CNT_W] >= isf_pkg::SAT_LEVEL)
            begin
                kinds = kinds + 1'b1;
            end
        end
        if (!s1_site_ok_reg)
        begin
            kinds = '0;
        end
    end

    assign s1_we = s1_valid_reg && s1_site_ok_reg
                   && ((s1_op_reg == isf_pkg::OP_CLASSIFY) || s1_base_ok_reg);

    // write port shared between clearing pass and write-back
    assign ram_we    = clearing_reg || s1_we;
    assign ram_waddr = clearing_reg ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = clearing_reg ? '0 : new_word;

    isf_ram #(
        .WIDTH (isf_pkg::WORD_W),
        .DEPTH (isf_pkg::SITES),
        .AW    (isf_pkg::ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (isf_pkg::ADDR_W'(in_site)),
        .rdata (rd_word)
    );

    assign clearing  = clearing_reg;
    assign pend      = s1_valid_reg && (s1_op_reg == isf_pkg::OP_CLASSIFY);
    assign push      = pend;
    assign res.kinds = kinds;
    assign res.keep  = (kinds >= isf_pkg::KEEP_MIN);

endmodule

@@ design/isf_outq.sv @@
// small result queue between the store pipeline and the output channel
`timescale 1ns / 1ps

module isf_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  isf_pkg::result_t    push_data,
    input  logic                pend,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output isf_pkg::result_t    out_data
);

    isf_pkg::result_t               entry_reg [isf_pkg::OQ_DEPTH];
    logic [isf_pkg::OQ_PTR_W-1:0]   wr_ptr_reg;
    logic [isf_pkg::OQ_PTR_W-1:0]   rd_ptr_reg;
    logic [isf_pkg::OQ_CNT_W-1:0]   cnt_reg;
    logic [isf_pkg::OQ_CNT_W-1:0]   cnt_next;
    logic [isf_pkg::OQ_CNT_W-1:0]   occ;
    logic                           pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // slots already promised: stored entries plus a classify still in flight
    assign occ  = cnt_reg + isf_pkg::OQ_CNT_W'(pend);
    assign room = (occ < isf_pkg::OQ_CNT_W'(isf_pkg::OQ_DEPTH))
                  || ((occ == isf_pkg::OQ_CNT_W'(isf_pkg::OQ_DEPTH)) && pop);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/informative_site_filter.sv @@
// top level of the parsimony-informative site filter
`timescale 1ns / 1ps

// Usage
// One input stream carries requests: tuser holds the opcode, count or
// classify, and tdata the site index and the raw base character. A count
// request raises the site's counter for A, C, G or T (either case), which
// stops at two; other characters change nothing. A classify request returns
// one result on the output stream: the number of bases seen at least twice
// and a keep flag, set when that number is two or more; the site is then
// cleared. Count requests return nothing.
// Throughput is one request per cycle while s_tready is high: the store is
// read in the accept cycle and written back in the next cycle, with the last
// written word forwarded when the next request hits the same site.
// A classify result passes the request stage register and then the result
// queue count before it raises m_tvalid. Results wait in a two-entry queue;
// when the receiver stalls, s_tready drops once every queue slot is promised.
// After reset the store is swept to zero, one site a cycle, across all 4096
// sites; s_tready stays low during the sweep.

module informative_site_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // site [11:0], base_char [19:12], zero [23:20]
    input  logic        s_tuser,   // opcode [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // kinds [2:0], keep [3], zero [7:4]
);

    logic               in_fire;
    logic               clearing;
    logic               pend;
    logic               push;
    logic               room;
    isf_pkg::result_t   res;
    isf_pkg::result_t   out_res;
    isf_pkg::opcode_t   in_op;

    // request handshake
    assign s_tready = !clearing && room;
    assign in_fire  = s_tvalid && s_tready;
    assign in_op    = isf_pkg::opcode_t'(s_tuser);

    isf_rmw u_rmw (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_op    (in_op),
        .in_site  (s_tdata[11:0]),
        .in_char  (s_tdata[19:12]),
        .clearing (clearing),
        .pend     (pend),
        .push     (push),
        .res      (res)
    );

    isf_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .pend      (pend),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // result packing
    assign m_tdata = {4'b0000, out_res.keep, out_res.kinds};

endmodule

@@ design/isf_checker.sv @@
// port-level checks of the informative site filter
`timescale 1ns / 1ps

module isf_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("isf: result withdrawn while stalled");

    // a stalled result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("isf: result changed while stalled");

    // keep flag agrees with the number of saturated bases
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3] == (m_tdata[2:0] >= 3'd2)))
        else $error("isf: keep flag inconsistent with kinds");

    // kinds never exceeds four and padding is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[2:0] <= 3'd4) && (m_tdata[7:4] == 4'd0)))
        else $error("isf: malformed result");

    // no request taken right after reset while the store is swept
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_tready)
        else $error("isf: request accepted during clearing pass");

endmodule

bind informative_site_filter isf_checker u_isf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
